[rtl/core/htsd_pkg.sv]
`default_nettype none

package htsd_pkg;

	localparam int TABLE_DEPTH = 512;
	localparam int COUNT_BITS  = 20;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int DONE_W      = 20;
	localparam int LEN_W       = 20;
	localparam int CMP_W       = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DATA = 1'b1;

	localparam logic [1:0] REG_END_CODE   = 2'd0;
	localparam logic [1:0] REG_NODE_COUNT = 2'd1;
	localparam logic [1:0] REG_OUT_LENGTH = 2'd2;

	typedef enum logic [1:0] {
		KIND_SYMBOL = 2'd0,
		KIND_END    = 2'd1,
		KIND_LENGTH = 2'd2
	} kind_t;

	typedef struct packed {
		logic [7:0]       end_code;
		logic [7:0]       node_count;
		logic [LEN_W-1:0] out_length;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [7:0]        symbol;
		kind_t             kind;
		logic [DONE_W-1:0] done;
	} result_t;

	// index reduced into the table depth by shift-and-subtract
	function automatic logic [ADDR_W-1:0] mod_depth(input logic [8:0] v);
		logic [9:0] r;
		r = {1'b0, v};
		for (int k = 8; k >= 0; k--) begin
			if ((TABLE_DEPTH << k) <= 511) begin
				if (r >= 10'(TABLE_DEPTH << k)) begin
					r = r - 10'(TABLE_DEPTH << k);
				end
			end
		end
		return ADDR_W'(r);
	endfunction

	// child b of node n sits at (n - end_code - 1) * 2 + b
	function automatic logic [ADDR_W-1:0] child_addr(input logic [8:0] node,
			input logic [7:0] end_code, input logic b);
		logic [7:0] rel;
		rel = node[7:0] - end_code - 8'd1;
		return mod_depth({rel, b});
	endfunction

endpackage

`default_nettype wire

[rtl/core/htsd_ram.sv]
`default_nettype none

module htsd_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 8
) (
	input  wire                                         clk,
	input  wire                                         we,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire [WIDTH-1:0]                             wdata,
	input  wire                                         re,
	input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/htsd_cfg_regs.sv]
`default_nettype none

module htsd_cfg_regs (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       cfg_valid,
	output logic                      cfg_ready,
	input  wire  [1:0]                cfg_index,
	input  wire  [htsd_pkg::LEN_W-1:0] cfg_data,
	output htsd_pkg::cfg_t            cfg
);

	import htsd_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_END_CODE:   cfg_q.end_code   <= cfg_data[7:0];
				REG_NODE_COUNT: cfg_q.node_count <= cfg_data[7:0];
				REG_OUT_LENGTH: cfg_q.out_length <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/htsd_walker.sv]
`default_nettype none

module htsd_walker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  htsd_pkg::cfg_t         cfg,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          in_op,
	input  wire  [8:0]                   in_addr,
	input  wire  [7:0]                   in_value,
	input  wire  [7:0]                   in_byte,
	output logic                         out_valid,
	input  wire                          out_ready,
	output htsd_pkg::result_t            out_res,
	output logic                         out_last,
	output htsd_pkg::ram_req_t           ram_req,
	input  wire  [7:0]                   ram_rdata
);

	import htsd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FLUSH
	} state_t;

	state_t                state_q;
	logic                  stopped_q;
	logic                  started_q;
	logic [8:0]            node_q;
	logic [COUNT_BITS-1:0] count_q;
	logic [7:0]            data_q;
	logic [2:0]            bit_q;
	logic                  pend_valid_q;
	result_t               pend_q;
	logic                  out_valid_q;
	result_t               out_q;
	logic                  out_last_q;

	logic                  in_fire;
	logic                  out_free;
	logic [8:0]            root;
	logic [8:0]            start_node;
	logic                  len_hit_now;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic                  inc_hit;
	logic                  is_end;
	logic                  is_leaf;
	logic                  has_res;
	logic                  stop_now;
	logic                  step_ok;
	logic [8:0]            next_node;
	result_t               res;
	logic                  push_mid;
	logic                  push_flush;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

	assign root        = 9'(cfg.end_code) + 9'(cfg.node_count);
	assign start_node  = started_q ? node_q : root;
	assign len_hit_now = CMP_W'(count_q) >= CMP_W'(cfg.out_length);
	assign cnt_inc     = count_q + COUNT_BITS'(1);
	assign inc_hit     = CMP_W'(cnt_inc) >= CMP_W'(cfg.out_length);

	assign is_end    = (ram_rdata == cfg.end_code);
	assign is_leaf   = (ram_rdata < cfg.end_code);
	assign has_res   = is_end || is_leaf;
	assign stop_now  = is_end || (is_leaf && inc_hit);
	assign next_node = is_leaf ? root : {1'b0, ram_rdata};
	assign step_ok   = (state_q == ST_WALK) && !(pend_valid_q && !out_free);

	always_comb begin
		res.symbol = is_end ? 8'd0 : ram_rdata;
		res.kind   = is_end ? KIND_END : (inc_hit ? KIND_LENGTH : KIND_SYMBOL);
		res.done   = is_end ? DONE_W'(count_q) : DONE_W'(cnt_inc);
	end

	assign push_mid   = step_ok && has_res && pend_valid_q;
	assign push_flush = (state_q == ST_FLUSH) && pend_valid_q && out_free;

	always_comb begin
		ram_req.we    = in_fire && !stopped_q && (in_op == OP_LOAD)
		                && (int'(in_addr) < TABLE_DEPTH);
		ram_req.waddr = ADDR_W'(in_addr);
		ram_req.wdata = in_value;
		ram_req.re    = (in_fire && !stopped_q && (in_op == OP_DATA) && !len_hit_now)
		                || (step_ok && !stop_now && (bit_q != 3'd7));
		if (state_q == ST_IDLE) begin
			ram_req.raddr = child_addr(start_node, cfg.end_code, in_byte[7]);
		end else begin
			ram_req.raddr = child_addr(next_node, cfg.end_code, data_q[7]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			stopped_q    <= 1'b0;
			started_q    <= 1'b0;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push_mid || push_flush) begin
				out_valid_q <= 1'b1;
				out_q       <= pend_q;
				out_last_q  <= push_flush;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire && !stopped_q && (in_op == OP_DATA)) begin
						started_q <= 1'b1;
						if (len_hit_now) begin
							pend_valid_q  <= 1'b1;
							pend_q.symbol <= 8'd0;
							pend_q.kind   <= KIND_LENGTH;
							pend_q.done   <= DONE_W'(count_q);
							stopped_q     <= 1'b1;
							state_q       <= ST_FLUSH;
						end else begin
							data_q  <= {in_byte[6:0], 1'b0};
							bit_q   <= 3'd0;
							state_q <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (step_ok) begin
						if (has_res) begin
							pend_valid_q <= 1'b1;
							pend_q       <= res;
						end
						if (is_leaf) begin
							count_q <= cnt_inc;
						end
						if (stop_now) begin
							stopped_q <= 1'b1;
							state_q   <= ST_FLUSH;
						end else begin
							node_q <= next_node;
							data_q <= {data_q[6:0], 1'b0};
							bit_q  <= bit_q + 3'd1;
							if (bit_q == 3'd7) begin
								state_q <= ST_FLUSH;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/huffman_tree_symbol_decoder_unit.sv]
// Tree-walk decoder. A table load (tuser 0) writes one byte of the code tree.
// A coded byte (tuser 1) is walked MSB first, one dependent read of the
// tree-table memory per bit: the byte is accepted, walked bit by bit and then
// hands over its final result, and a stall on the output side holds the walk.
// The walk stops early on the end code or when out_length symbols are out;
// from then on every beat is taken and dropped until reset. The tree table
// has no reset and needs no clearing pass.
`default_nettype none

module huffman_tree_symbol_decoder_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // table_addr[8:0], table_value[16:9], data_byte[24:17]
	input  wire         s_axis_tuser,  // op
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [31:0] m_axis_tdata,  // symbol[7:0], symbols_done[27:8]
	output logic [1:0]  m_axis_tuser,  // kind
	output logic        m_axis_tlast,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [19:0] cfg_data
);

	import htsd_pkg::*;

	cfg_t     cfg;
	ram_req_t ram_req;
	result_t  res;
	logic [7:0] ram_rdata;

	htsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	htsd_ram #(
		.DEPTH (TABLE_DEPTH),
		.WIDTH (8)
	) u_table (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	htsd_walker u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_addr   (s_axis_tdata[8:0]),
		.in_value  (s_axis_tdata[16:9]),
		.in_byte   (s_axis_tdata[24:17]),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.out_last  (m_axis_tlast),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	assign m_axis_tdata = {4'd0, res.done, res.symbol};
	assign m_axis_tuser = res.kind;

endmodule

`default_nettype wire

[rtl/core/htsd_checker.sv]
`default_nettype none

module htsd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [31:0] m_axis_tdata,
	input wire [1:0]  m_axis_tuser,
	input wire        m_axis_tlast
);

	import htsd_pkg::*;

	// stalled beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("output beat changed while stalled");

	// a stop beat always closes its byte
	a_stop_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != KIND_SYMBOL) |-> m_axis_tlast)
		else $error("stop beat without tlast");

	// nothing follows a stop beat
	a_stop_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && (m_axis_tuser != KIND_SYMBOL)
		|=> !m_axis_tvalid)
		else $error("beat after stop");

	// a plain symbol beat counts at least one symbol
	a_sym_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == KIND_SYMBOL) |-> (m_axis_tdata[27:8] != 20'd0))
		else $error("symbol beat with zero count");

endmodule

bind huffman_tree_symbol_decoder_unit htsd_checker u_htsd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
